// ===== rtl/core/hse_pkg.sv =====
package hse_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned DW    = 32;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned KW    = AW + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SD_RD,
    ST_SD_HELD,
    ST_SD_K0,
    ST_SD_K1,
    ST_SD_WR,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/core/heap_sort_engine.sv =====
// Heap sort engine.
// Input: a transfer happens on a rising edge with start high and busy low.
// Each transfer carries value_i (signed 32 bits) and last_i. Values are
// written into a local store of DEPTH entries, one entry per transfer;
// values beyond DEPTH are dropped and flag overflow for the set.
// On a transfer with last_i set, busy rises and the engine heapifies the
// set and heap-sorts it in place in a single-port-read RAM. Each sift level
// reads one child or both, a heapify sift-down also reads the root and
// writes the held value back, and each extraction swaps root and last
// entry (states SW0, SW1, SW2) ahead of its sift-down and write-back.
// Results then stream out one per cycle, ascending, on value_res_o with
// res_strobe_o high for exactly one cycle each; last_res_o marks the final
// one and overflow_o tells whether values were dropped. The final strobe
// is in the first cycle with busy low. The receiver cannot stall: every
// strobed result is taken. Reset clears the count, the overflow flag and
// the control state; the store contents are not cleared and need not be.
module heap_sort_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [hse_pkg::DW-1:0] value_i,
  input  logic                          last_i,
  output logic                          res_strobe_o,
  output logic signed [hse_pkg::DW-1:0] value_res_o,
  output logic                          last_res_o,
  output logic                          overflow_o
);
  import hse_pkg::*;

  ram_req_t      ram_req;
  logic [DW-1:0] ram_rdata;

  hse_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .value_i      (value_i),
    .last_i       (last_i),
    .busy_o       (busy),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .res_strobe_o (res_strobe_o),
    .res_last_o   (last_res_o),
    .res_ovf_o    (overflow_o)
  );

  hse_ram #(
    .W (DW),
    .D (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign value_res_o = $signed(ram_rdata);

endmodule

// ===== rtl/core/hse_ram.sv =====
module hse_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hse_ctrl.sv =====
module hse_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [hse_pkg::DW-1:0] value_i,
  input  logic                      last_i,
  output logic                      busy_o,
  output hse_pkg::ram_req_t         ram_req_o,
  input  logic [hse_pkg::DW-1:0]    ram_rdata_i,
  output logic                      res_strobe_o,
  output logic                      res_last_o,
  output logic                      res_ovf_o
);
  import hse_pkg::*;

  state_e state_q, state_d;

  logic          extract_q, extract_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] len_q, len_d;
  logic [AW-1:0] root_q, root_d;
  logic [AW-1:0] end_q, end_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [KW-1:0] kid_q, kid_d;
  logic [AW-1:0] k_q, k_d;
  logic signed [DW-1:0] held_q, held_d;
  logic signed [DW-1:0] kv_q, kv_d;
  logic signed [DW-1:0] t0_q, t0_d;
  logic          res_vld_q, res_vld_d;
  logic          res_last_q, res_last_d;
  logic          res_ovf_q, res_ovf_d;

  logic signed [DW-1:0] rdata;
  logic          accept;
  logic          room;
  logic [CW-1:0] n_now;
  logic          has2;
  logic          pick_hi;
  logic signed [DW-1:0] best;
  logic [AW-1:0] bidx;
  logic          take;
  logic [KW-1:0] kid_nx;
  logic          kid_nx_ok;
  logic [KW-1:0] kid_root;
  logic          kid_root_ok;
  logic          emit_end;

  assign rdata       = $signed(ram_rdata_i);
  assign accept      = start_i && (state_q == ST_IDLE);
  assign room        = cnt_q < CW'(DEPTH);
  assign n_now       = room ? cnt_q + CW'(1) : cnt_q;
  assign has2        = ({1'b0, kid_q} + (KW+1)'(1)) < (KW+1)'(len_q);
  assign pick_hi     = (state_q == ST_SD_K1) && (kv_q < rdata);
  assign best        = ((state_q == ST_SD_K1) && !pick_hi) ? kv_q : rdata;
  assign bidx        = kid_q[AW-1:0] + AW'(pick_hi);
  assign take        = held_q < best;
  assign kid_nx      = {bidx, 1'b1};
  assign kid_nx_ok   = kid_nx < KW'(len_q);
  assign kid_root    = {root_q, 1'b1};
  assign kid_root_ok = kid_root < KW'(len_q);
  assign emit_end    = k_q == AW'(cnt_q - CW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_i) begin
          state_d = (n_now == CW'(1)) ? ST_EMIT : ST_SD_RD;
        end
      end
      ST_SD_RD:   state_d = ST_SD_HELD;
      ST_SD_HELD: state_d = kid_root_ok ? ST_SD_K0 : ST_SD_WR;
      ST_SD_K0: begin
        if (has2) begin
          state_d = ST_SD_K1;
        end else begin
          state_d = (take && kid_nx_ok) ? ST_SD_K0 : ST_SD_WR;
        end
      end
      ST_SD_K1:   state_d = (take && kid_nx_ok) ? ST_SD_K0 : ST_SD_WR;
      ST_SD_WR: begin
        if (!extract_q) begin
          state_d = (root_q == '0) ? ST_SW0 : ST_SD_RD;
        end else begin
          state_d = (end_q == AW'(1)) ? ST_EMIT : ST_SW0;
        end
      end
      ST_SW0:     state_d = ST_SW1;
      ST_SW1:     state_d = ST_SW2;
      ST_SW2:     state_d = (end_q > AW'(1)) ? ST_SD_K0 : ST_SD_WR;
      ST_EMIT:    state_d = emit_end ? ST_IDLE : ST_EMIT;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    ram_req_o  = '0;
    extract_d  = extract_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    len_d      = len_q;
    root_d     = root_q;
    end_d      = end_q;
    pos_d      = pos_q;
    kid_d      = kid_q;
    k_d        = k_q;
    held_d     = held_q;
    kv_d       = kv_q;
    t0_d       = t0_q;
    res_vld_d  = 1'b0;
    res_last_d = 1'b0;
    res_ovf_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ram_req_o.we    = room;
          ram_req_o.waddr = cnt_q[AW-1:0];
          ram_req_o.wdata = value_i;
          cnt_d           = n_now;
          drop_d          = drop_q | !room;
          len_d           = n_now;
          root_d          = AW'((n_now - CW'(1)) >> 1);
          extract_d       = 1'b0;
          k_d             = '0;
        end
      end
      ST_SD_RD: begin
        ram_req_o.raddr = root_q;
      end
      ST_SD_HELD: begin
        held_d          = rdata;
        pos_d           = root_q;
        kid_d           = kid_root;
        ram_req_o.raddr = kid_root[AW-1:0];
      end
      ST_SD_K0, ST_SD_K1: begin
        if ((state_q == ST_SD_K0) && has2) begin
          kv_d            = rdata;
          ram_req_o.raddr = AW'(kid_q + KW'(1));
        end else if (take) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = pos_q;
          ram_req_o.wdata = best;
          pos_d           = bidx;
          kid_d           = kid_nx;
          ram_req_o.raddr = kid_nx[AW-1:0];
        end
      end
      ST_SD_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos_q;
        ram_req_o.wdata = held_q;
        if (!extract_q) begin
          if (root_q == '0) begin
            extract_d = 1'b1;
            end_d     = AW'(len_q - CW'(1));
          end else begin
            root_d = root_q - AW'(1);
          end
        end else begin
          end_d = end_q - AW'(1);
        end
      end
      ST_SW0: begin
        ram_req_o.raddr = '0;
      end
      ST_SW1: begin
        t0_d            = rdata;
        ram_req_o.raddr = end_q;
      end
      ST_SW2: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = end_q;
        ram_req_o.wdata = t0_q;
        held_d          = rdata;
        pos_d           = '0;
        kid_d           = KW'(1);
        len_d           = CW'(end_q);
        ram_req_o.raddr = AW'(1);
      end
      ST_EMIT: begin
        ram_req_o.raddr = k_q;
        res_vld_d       = 1'b1;
        res_last_d      = emit_end;
        res_ovf_d       = drop_q;
        if (emit_end) begin
          cnt_d  = '0;
          drop_d = 1'b0;
          k_d    = '0;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    extract_q  <= extract_d;
    len_q      <= len_d;
    root_q     <= root_d;
    end_q      <= end_d;
    pos_q      <= pos_d;
    kid_q      <= kid_d;
    k_q        <= k_d;
    held_q     <= held_d;
    kv_q       <= kv_d;
    t0_q       <= t0_d;
    res_last_q <= res_last_d;
    res_ovf_q  <= res_ovf_d;
  end

  assign busy_o       = state_q != ST_IDLE;
  assign res_strobe_o = res_vld_q;
  assign res_last_o   = res_last_q;
  assign res_ovf_o    = res_ovf_q;

endmodule

// ===== rtl/core/heap_sort_engine_chk.sv =====
module heap_sort_engine_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_i,
  input logic res_strobe_o,
  input logic last_res_o,
  input logic overflow_o
);

  a_no_res_mid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !last_i |=> !res_strobe_o)
    else $error("result after a non-final transfer");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_i |=> busy)
    else $error("busy not raised after final transfer");

  a_stream_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_res_o |=> res_strobe_o)
    else $error("gap in result stream");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_res_o |=> !res_strobe_o)
    else $error("result after final result");

  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_res_o |=> overflow_o == $past(overflow_o))
    else $error("overflow changed within a set");

endmodule

bind heap_sort_engine heap_sort_engine_chk u_chk (.*);

// ===== verif/heap_sort_checker.sv =====
module heap_sort_checker
  import hse_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic signed [DW-1:0] value_i,
  input  logic                 last_i,
  input  logic                 res_strobe_i,
  input  logic signed [DW-1:0] value_res_i,
  input  logic                 last_res_i,
  input  logic                 overflow_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          last;
    logic          ovf;
  } sorted_elem_t;

  logic signed [DW-1:0] held_vals [DEPTH];
  int unsigned          held_count = 0;
  logic                 held_dropped = 1'b0;
  sorted_elem_t         ascending_q [$];
  int                   fails = 0;
  int                   pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic flag_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    fails++;
  endtask

  // insertion sort of the held set, signed ascending
  task automatic sort_held();
    logic signed [DW-1:0] key;
    int j;
    for (int i = 1; i < held_count; i++) begin
      key = held_vals[i];
      j = i - 1;
      while (j >= 0 && held_vals[j] > key) begin
        held_vals[j+1] = held_vals[j];
        j--;
      end
      held_vals[j+1] = key;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_elem_t want;
    if (!rst_ni) begin
      held_count   = 0;
      held_dropped = 1'b0;
      ascending_q.delete();
    end else begin
      if (res_strobe_i) begin
        if (ascending_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value_res %0d", value_res_i));
        end else begin
          want = ascending_q.pop_front();
          if (value_res_i !== $signed(want.val))
            flag_mismatch($sformatf("value_res %0d, want %0d", value_res_i,
                                    $signed(want.val)));
          if (last_res_i !== want.last)
            flag_mismatch($sformatf("last_res %b, want %b", last_res_i, want.last));
          if (overflow_i !== want.ovf)
            flag_mismatch($sformatf("overflow %b, want %b", overflow_i, want.ovf));
        end
      end
      // input transfer
      if (start_i && !busy_i) begin
        if (held_count < DEPTH) begin
          held_vals[held_count] = value_i;
          held_count++;
        end else begin
          held_dropped = 1'b1;
        end
        if (last_i) begin
          sort_held();
          for (int k = 0; k < held_count; k++) begin
            want.val  = held_vals[k];
            want.last = (k + 1 == held_count);
            want.ovf  = held_dropped;
            ascending_q.push_back(want);
          end
          held_count   = 0;
          held_dropped = 1'b0;
        end
      end
    end
    pending = ascending_q.size();
  end

endmodule

// ===== verif/heap_sort_engine_tb.sv =====
module heap_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hse_pkg::*;

  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 20;

  localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start   = 1'b0;
  logic signed [DW-1:0] value_i = '0;
  logic                 last_i  = 1'b0;
  logic                 busy;
  logic                 res_strobe_o;
  logic signed [DW-1:0] value_res_o;
  logic                 last_res_o;
  logic                 overflow_o;
  int                   fail_count;
  int                   pending_count;
  int                   gap_pct = 0;
  int                   sent    = 0;

  always #5 clk_i = ~clk_i;

  heap_sort_engine uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .last_i       (last_i),
    .res_strobe_o (res_strobe_o),
    .value_res_o  (value_res_o),
    .last_res_o   (last_res_o),
    .overflow_o   (overflow_o)
  );

  heap_sort_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .value_i      (value_i),
    .last_i       (last_i),
    .res_strobe_i (res_strobe_o),
    .value_res_i  (value_res_o),
    .last_res_i   (last_res_o),
    .overflow_i   (overflow_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(5))
      0:       return MIN_VAL;
      1:       return MAX_VAL;
      2:       return $urandom_range(8) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_elem(input logic signed [DW-1:0] v, input logic l);
    while ($urandom_range(99) < gap_pct) begin
      start   <= 1'b0;
      value_i <= $urandom;
      last_i  <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    last_i  <= l;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic push_random_set(input int n);
    for (int i = 0; i < n; i++)
      push_elem(pick_value(), i == n - 1);
  endtask

  initial begin
    logic signed [DW-1:0] mixed [9];
    int phase_end;
    mixed = '{32'sd0, -32'sd1, MAX_VAL, MIN_VAL, 32'sd1, -32'sd1, MAX_VAL, 32'sd0, MIN_VAL};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element sets at both extremes
    push_elem(MIN_VAL, 1'b1);
    push_elem(MAX_VAL, 1'b1);
    // extremes with duplicates
    foreach (mixed[i]) push_elem(mixed[i], i == 8);
    // already descending, then already ascending
    for (int i = 5; i >= 1; i--) push_elem(i, i == 1);
    for (int i = -2; i <= 2; i++) push_elem(i, i == 2);

    for (int p = 0; p < 3; p++) begin
      gap_pct   = (p == 0) ? 28 : (p == 1) ? 83 : 0;
      phase_end = sent + PHASE_ITEMS;
      // just below full, exactly full, last transfer dropped
      push_random_set(63 + p);
      while (sent < phase_end) begin
        if ($urandom_range(11) == 0) push_random_set($urandom_range(60, 70));
        else push_random_set($urandom_range(1, 10));
      end
    end

    start <= 1'b0;
    // let the checker take the final transfer into account
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("heap_sort_engine_tb passed");
    end else begin
      $display("heap_sort_engine_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("heap_sort_engine_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hse_pkg.sv
rtl/core/hse_ram.sv
rtl/core/hse_ctrl.sv
rtl/core/heap_sort_engine.sv
rtl/core/heap_sort_engine_chk.sv
verif/heap_sort_checker.sv
verif/heap_sort_engine_tb.sv
